### rtl/bmpt_pkg.sv
// Package for the binomial coefficient block: table sizes, register indexes,
// build sequencer states and the shared modular reduction step.
// No dependencies.
package bmpt_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int MOD_W         = 31;
    localparam int PROD_W        = 2 * MOD_W;
    localparam int REDUCE_STAGES = PROD_W / 2;
    localparam int CNT_W         = $clog2(REDUCE_STAGES);
    localparam int IDX_W         = 2;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = MOD_W'(1000000007);
    localparam logic [ADDR_W-1:0] LIMIT_RESET   = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [IDX_W-1:0] {
        REG_MODULUS = 2'd0,
        REG_LIMIT   = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_SEED0,
        S_SEED1,
        S_DIV,
        S_RDINV,
        S_MUL,
        S_RED,
        S_WRITE,
        S_DONE
    } t_build_state;

    typedef enum logic [1:0] {
        PH_INV,
        PH_FACT,
        PH_IFACT
    } t_phase;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [MOD_W-1:0]  fact;
        logic [MOD_W-1:0]  inv;
        logic [MOD_W-1:0]  ifact;
    } t_tbl_wr;

    // One bit of a restoring reduction: shift in a bit, subtract the modulus at most once.
    function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[MOD_W-1:0];
    endfunction

endpackage

### rtl/bmpt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bmpt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bmpt_reduce.sv
// Pipelined reduction of a 62-bit product modulo the modulus, two bits per stage.
// Depends on bmpt_pkg.
module bmpt_reduce import bmpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [MOD_W-1:0]  i_mod,
    input  logic              i_vld,
    input  logic [PROD_W-1:0] i_x,
    input  logic [MOD_W:0]    i_side,
    output logic              o_vld,
    output logic [MOD_W-1:0]  o_rem,
    output logic [MOD_W:0]    o_side
);

    logic              r_vld  [REDUCE_STAGES];
    logic [MOD_W-1:0]  r_rem  [REDUCE_STAGES];
    logic [PROD_W-1:0] r_x    [REDUCE_STAGES];
    logic [MOD_W:0]    r_side [REDUCE_STAGES];

    for (genvar j = 0; j < REDUCE_STAGES; j++) begin : g_stage
        logic              w_vld;
        logic [MOD_W-1:0]  w_rem;
        logic [PROD_W-1:0] w_x;
        logic [MOD_W:0]    w_side;

        if (j == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_x    = i_x;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_x    = r_x[j-1];
            assign w_side = r_side[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= mod_step(mod_step(w_rem, w_x[PROD_W-1], i_mod),
                                      w_x[PROD_W-2], i_mod);
                r_x[j]    <= {w_x[PROD_W-3:0], 2'b00};
                r_side[j] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[REDUCE_STAGES-1];
    assign o_rem  = r_rem[REDUCE_STAGES-1];
    assign o_side = r_side[REDUCE_STAGES-1];

endmodule

### rtl/bmpt_build.sv
// Table build sequencer: seeds entries 0 and 1, then derives each further entry
// with an iterative divider and an iterative modular reduction. Depends on bmpt_pkg.
module bmpt_build import bmpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [MOD_W-1:0]  i_mod,
    input  logic [ADDR_W-1:0] i_limit,
    input  logic [MOD_W-1:0]  i_inv_rdata,
    output logic [ADDR_W-1:0] o_inv_raddr,
    output t_tbl_wr           o_wr,
    output logic              o_done
);

    t_build_state      r_state, n_state;
    t_phase            r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_i;
    logic [ADDR_W-1:0] r_drem;
    logic [MOD_W-1:0]  r_dnum;
    logic [MOD_W-1:0]  r_dq;
    logic [PROD_W-1:0] r_prod;
    logic [MOD_W-1:0]  r_rem;
    logic [MOD_W-1:0]  r_fprev;
    logic [MOD_W-1:0]  r_ifprev;
    logic [MOD_W-1:0]  r_inv;

    logic [ADDR_W:0]   w_dtrial;
    logic              w_dge;
    logic [MOD_W-1:0]  w_red;
    logic [MOD_W-1:0]  w_opa;
    logic [MOD_W-1:0]  w_opb;
    logic              w_last;

    assign w_dtrial = {r_drem, r_dnum[MOD_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_i});
    assign w_red    = mod_step(mod_step(r_rem, r_prod[PROD_W-1], i_mod),
                               r_prod[PROD_W-2], i_mod);
    assign w_last   = (r_cnt == CNT_W'(REDUCE_STAGES - 1));

    always_comb begin
        case (r_phase)
            PH_INV: begin
                w_opa = i_inv_rdata;
                w_opb = r_dq;
            end
            PH_FACT: begin
                w_opa = r_fprev;
                w_opb = {{(MOD_W-ADDR_W){1'b0}}, r_i};
            end
            default: begin
                w_opa = r_ifprev;
                w_opb = r_inv;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SEED0: n_state = S_SEED1;
            S_SEED1: n_state = (i_limit < ADDR_W'(2)) ? S_DONE : S_DIV;
            S_DIV:   n_state = (r_cnt == CNT_W'(MOD_W - 1)) ? S_RDINV : S_DIV;
            S_RDINV: n_state = S_MUL;
            S_MUL:   n_state = S_RED;
            S_RED: begin
                if (w_last) begin
                    n_state = (r_phase == PH_IFACT) ? S_WRITE : S_MUL;
                end
            end
            S_WRITE: n_state = (r_i == i_limit) ? S_DONE : S_DIV;
            S_DONE:  n_state = S_DONE;
            default: n_state = S_SEED0;
        endcase
        if (i_restart) begin
            n_state = S_SEED0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEED0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SEED1: begin
                r_i      <= ADDR_W'(2);
                r_fprev  <= MOD_W'(1);
                r_ifprev <= MOD_W'(1);
                r_drem   <= '0;
                r_dnum   <= i_mod;
                r_cnt    <= '0;
            end
            S_DIV: begin
                r_drem <= w_dge ? ADDR_W'(w_dtrial - {1'b0, r_i}) : w_dtrial[ADDR_W-1:0];
                r_dq   <= {r_dq[MOD_W-2:0], w_dge};
                r_dnum <= {r_dnum[MOD_W-2:0], 1'b0};
                r_cnt  <= r_cnt + CNT_W'(1);
                r_phase <= PH_INV;
            end
            S_MUL: begin
                r_prod <= {{MOD_W{1'b0}}, w_opa} * {{MOD_W{1'b0}}, w_opb};
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            S_RED: begin
                r_rem  <= w_red;
                r_prod <= {r_prod[PROD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    case (r_phase)
                        PH_INV: begin
                            r_inv   <= i_mod - w_red;
                            r_phase <= PH_FACT;
                        end
                        PH_FACT: begin
                            r_fprev <= w_red;
                            r_phase <= PH_IFACT;
                        end
                        default: begin
                            r_ifprev <= w_red;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                r_i    <= r_i + ADDR_W'(1);
                r_drem <= '0;
                r_dnum <= i_mod;
                r_cnt  <= '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_wr.en    = 1'b0;
        o_wr.addr  = r_i;
        o_wr.fact  = r_fprev;
        o_wr.inv   = r_inv;
        o_wr.ifact = r_ifprev;
        unique case (r_state)
            S_SEED0: begin
                o_wr.en    = 1'b1;
                o_wr.addr  = '0;
                o_wr.fact  = MOD_W'(1);
                o_wr.inv   = '0;
                o_wr.ifact = MOD_W'(1);
            end
            S_SEED1: begin
                o_wr.en    = 1'b1;
                o_wr.addr  = ADDR_W'(1);
                o_wr.fact  = MOD_W'(1);
                o_wr.inv   = MOD_W'(1);
                o_wr.ifact = MOD_W'(1);
            end
            S_WRITE: o_wr.en = 1'b1;
            default: o_wr.en = 1'b0;
        endcase
    end

    assign o_inv_raddr = r_drem;
    assign o_done      = (r_state == S_DONE);

endmodule

### rtl/binomial_mod_prime_table.sv
// Accepts one transaction per cycle once the table build is done and the output is not stalled.
// The pipeline is a table read, a multiply, 31 reduction stages, a second
// multiply, 31 more reduction stages and the output register.
// After reset and after each write to the modulus or limit register the tables
// are rebuilt with the iterative divider and reducer. Reset is synchronous,
// active low.
module binomial_mod_prime_table import bmpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [MOD_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ADDR_W-1:0] i_top_count,
    input  logic [ADDR_W-1:0] i_choose_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MOD_W-1:0]  o_coefficient,
    output logic              o_range_error
);

    logic [MOD_W-1:0]  r_mod;
    logic [ADDR_W-1:0] r_lim;
    logic [MOD_W-1:0]  w_meff;
    logic              w_restart;
    logic              w_en;
    logic              w_done;
    logic              w_acc;
    t_tbl_wr           w_wr;
    logic [ADDR_W-1:0] w_inv_raddr;
    logic [MOD_W-1:0]  w_inv_rdata;
    logic [MOD_W-1:0]  w_fact_rd;
    logic [MOD_W-1:0]  w_ifa_rd;
    logic [MOD_W-1:0]  w_ifb_rd;

    logic              r_s1_vld, r_s1_err;
    logic              r_s2_vld;
    logic [PROD_W-1:0] r_s2_p;
    logic [MOD_W:0]    r_s2_side;
    logic              w_r1_vld;
    logic [MOD_W-1:0]  w_r1_rem;
    logic [MOD_W:0]    w_r1_side;
    logic              r_s3_vld;
    logic [PROD_W-1:0] r_s3_p;
    logic              r_s3_err;
    logic              w_r2_vld;
    logic [MOD_W-1:0]  w_r2_rem;
    logic [MOD_W:0]    w_r2_side;
    logic              r_out_vld;
    logic [MOD_W-1:0]  r_out_coef;
    logic              r_out_err;

    assign w_restart = i_cfg_we &&
                       (i_cfg_index == REG_MODULUS || i_cfg_index == REG_LIMIT);
    assign w_meff    = (r_mod == '0) ? MOD_W'(1) : r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MODULUS_RESET;
            r_lim <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MODULUS) begin
                r_mod <= i_cfg_data;
            end
            if (i_cfg_index == REG_LIMIT) begin
                r_lim <= i_cfg_data[ADDR_W-1:0];
            end
        end
    end

    bmpt_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_mod       (w_meff),
        .i_limit     (r_lim),
        .i_inv_rdata (w_inv_rdata),
        .o_inv_raddr (w_inv_raddr),
        .o_wr        (w_wr),
        .o_done      (w_done)
    );

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en && w_done;
    assign w_acc      = i_in_valid && o_in_ready;

    bmpt_ram #(.WIDTH(MOD_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
        .i_clk (i_clk), .i_we (w_wr.en), .i_waddr (w_wr.addr), .i_wdata (w_wr.inv),
        .i_re (1'b1), .i_raddr (w_inv_raddr), .o_rdata (w_inv_rdata)
    );

    bmpt_ram #(.WIDTH(MOD_W), .DEPTH(TABLE_DEPTH)) u_fact_ram (
        .i_clk (i_clk), .i_we (w_wr.en), .i_waddr (w_wr.addr), .i_wdata (w_wr.fact),
        .i_re (w_en), .i_raddr (i_top_count), .o_rdata (w_fact_rd)
    );

    bmpt_ram #(.WIDTH(MOD_W), .DEPTH(TABLE_DEPTH)) u_ifact_a_ram (
        .i_clk (i_clk), .i_we (w_wr.en), .i_waddr (w_wr.addr), .i_wdata (w_wr.ifact),
        .i_re (w_en), .i_raddr (i_choose_count), .o_rdata (w_ifa_rd)
    );

    bmpt_ram #(.WIDTH(MOD_W), .DEPTH(TABLE_DEPTH)) u_ifact_b_ram (
        .i_clk (i_clk), .i_we (w_wr.en), .i_waddr (w_wr.addr), .i_wdata (w_wr.ifact),
        .i_re (w_en), .i_raddr (i_top_count - i_choose_count), .o_rdata (w_ifb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= w_acc;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= w_r1_vld;
            r_out_vld <= w_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_err   <= (i_choose_count > i_top_count) || (i_top_count > r_lim);
            r_s2_p     <= {{MOD_W{1'b0}}, w_fact_rd} * {{MOD_W{1'b0}}, w_ifa_rd};
            r_s2_side  <= {r_s1_err, w_ifb_rd};
            r_s3_p     <= {{MOD_W{1'b0}}, w_r1_rem} *
                          {{MOD_W{1'b0}}, w_r1_side[MOD_W-1:0]};
            r_s3_err   <= w_r1_side[MOD_W];
            r_out_coef <= w_r2_side[MOD_W] ? '0 : w_r2_rem;
            r_out_err  <= w_r2_side[MOD_W];
        end
    end

    bmpt_reduce u_reduce1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_mod (w_meff),
        .i_vld (r_s2_vld), .i_x (r_s2_p), .i_side (r_s2_side),
        .o_vld (w_r1_vld), .o_rem (w_r1_rem), .o_side (w_r1_side)
    );

    bmpt_reduce u_reduce2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_mod (w_meff),
        .i_vld (r_s3_vld), .i_x (r_s3_p), .i_side ({r_s3_err, {MOD_W{1'b0}}}),
        .o_vld (w_r2_vld), .o_rem (w_r2_rem), .o_side (w_r2_side)
    );

    assign o_out_valid   = r_out_vld;
    assign o_coefficient = r_out_coef;
    assign o_range_error = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_coefficient == '0))
        else $error("Range error with a non-zero coefficient.");

    a_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coefficient < w_meff))
        else $error("Coefficient not reduced below the modulus.");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_s1_vld)
        else $error("Accepted transaction did not enter the pipeline.");

endmodule
